// ===== src/cmtm_pkg.sv =====
// cmtm_pkg: shared types and constants for the chroma mean threshold mask
// no dependencies
`default_nettype none
package cmtm_pkg;
  localparam int unsigned SUM_W = 28;
  localparam int unsigned CNT_W = 21;
  // frame capacity in counted pixels; sums and count are sized for it
  localparam int unsigned MAX_FRAME_PIXELS = 1048576;

  typedef enum logic [2:0] {
    REG_BLACK  = 3'd0,
    REG_RED    = 3'd1,
    REG_BLUE   = 3'd2,
    REG_TOP    = 3'd3,
    REG_SELECT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_NORM = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // one classified item passed from front to back
  typedef struct packed {
    logic       cmd;
    logic       last;
    logic       lit;
    logic       below_top;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] total;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic       mask_bit;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       empty_frame;
  } result_t;
endpackage
`default_nettype wire

// ===== src/cmtm_front.sv =====
// cmtm_front: accepts pixels, computes channel sum and classifies them
// depends on cmtm_pkg
`default_nettype none
module cmtm_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [35:0]     in_data,
  input  wire logic [9:0]      black_limit,
  input  wire logic [9:0]      top_line,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output cmtm_pkg::item_t      q_item
);
  logic [9:0] total;

  assign in_ready = !q_valid || q_ready;
  assign total = 10'(in_data[8:1]) + 10'(in_data[16:9]) + 10'(in_data[24:17]);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_item.cmd       <= in_data[0];
      q_item.red       <= in_data[8:1];
      q_item.green     <= in_data[16:9];
      q_item.blue      <= in_data[24:17];
      q_item.last      <= in_data[35];
      q_item.total     <= total;
      q_item.lit       <= total > black_limit;
      q_item.below_top <= in_data[34:25] > top_line;
    end
  end
endmodule
`default_nettype wire

// ===== src/cmtm_back.sv =====
// cmtm_back: normalises, accumulates, divides at frame end and classifies
// depends on cmtm_pkg; one shared bit-serial divider
`default_nettype none
module cmtm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire cmtm_pkg::item_t  q_item,
  input  wire logic [7:0]       red_limit,
  input  wire logic [7:0]       blue_limit,
  input  wire logic             select_blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cmtm_pkg::result_t     out_res
);
  localparam int unsigned SW = cmtm_pkg::SUM_W;
  localparam int unsigned CW = cmtm_pkg::CNT_W;
  localparam logic [4:0] NORM_LAST = 5'd15;       // 16 steps for c*256/total
  localparam logic [4:0] MEAN_LAST = 5'(SW - 1);  // full width steps for sum/count

  cmtm_pkg::state_t state, state_next;
  cmtm_pkg::item_t  it;
  logic [1:0]    ch;          // channel under division
  logic [4:0]    step;        // bit step of divider
  logic [SW-1:0] rem;
  logic [SW-1:0] quo;
  logic [SW-1:0] divisor;
  logic [SW-1:0] dividend;
  logic [7:0]    n_r, n_g, n_b;
  logic [SW-1:0] sum_red, sum_green, sum_blue;
  logic [CW-1:0] pixel_count;
  logic [7:0]    mean_red, mean_green, mean_blue;
  logic [SW:0]   rem_sh;
  logic          fits;
  logic [SW-1:0] rem_next;
  logic [SW-1:0] quo_next;
  logic          div_done;
  logic [7:0]    sat;
  logic [7:0]    val;
  logic          room;
  logic [SW-1:0] add_red, add_green, add_blue;
  logic [CW-1:0] count_next;

  // restoring divider step
  assign rem_sh   = {rem, dividend[SW-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign rem_next = fits ? SW'(rem_sh - {1'b0, divisor}) : rem_sh[SW-1:0];
  assign quo_next = {quo[SW-2:0], fits};
  assign div_done = (step == ((state == cmtm_pkg::ST_NORM) ? NORM_LAST : MEAN_LAST));
  assign sat      = (quo_next > SW'(255)) ? 8'd255 : quo_next[7:0];

  // frame capacity check and sums including the pixel in hand
  assign room       = pixel_count < CW'(cmtm_pkg::MAX_FRAME_PIXELS);
  assign add_red    = sum_red + SW'(n_r);
  assign add_green  = sum_green + SW'(n_g);
  assign add_blue   = sum_blue + SW'(sat);
  assign count_next = pixel_count + CW'(1);

  always_comb begin
    state_next = state;
    case (state)
      cmtm_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.lit) state_next = cmtm_pkg::ST_NORM;
          else if (q_item.cmd) state_next = cmtm_pkg::ST_OUT;
          else if (q_item.last)
            state_next = (pixel_count == '0) ? cmtm_pkg::ST_OUT : cmtm_pkg::ST_DIV;
        end
      end
      cmtm_pkg::ST_NORM: begin
        if (div_done && ch == 2'd2) begin
          if (it.cmd) state_next = cmtm_pkg::ST_OUT;
          else if (it.last) state_next = cmtm_pkg::ST_DIV;
          else state_next = cmtm_pkg::ST_IDLE;
        end
      end
      cmtm_pkg::ST_DIV: begin
        if (div_done && ch == 2'd2) state_next = cmtm_pkg::ST_OUT;
      end
      cmtm_pkg::ST_OUT: begin
        if (!out_valid) state_next = cmtm_pkg::ST_IDLE;
      end
      default: state_next = cmtm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == cmtm_pkg::ST_IDLE);
  end

  always_comb begin
    if (select_blue) val = (n_b > mean_blue) ? n_b - mean_blue : 8'd0;
    else             val = (n_r > mean_red) ? n_r - mean_red : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmtm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      sum_red <= '0; sum_green <= '0; sum_blue <= '0;
      pixel_count <= '0;
      mean_red <= '0; mean_green <= '0; mean_blue <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      state <= state_next;
      case (state)
        cmtm_pkg::ST_IDLE: begin
          if (q_valid) begin
            it <= q_item;
            n_r <= '0; n_g <= '0; n_b <= '0;
            ch <= 2'd0; step <= '0; rem <= '0; quo <= '0;
            if (q_item.lit) begin
              divisor <= SW'(q_item.total);
              dividend <= {q_item.red, {(SW-8){1'b0}}};
            end else begin
              divisor <= SW'(pixel_count);
              dividend <= sum_red;
            end
            // empty frame: means fall back to zero
            if (!q_item.lit && !q_item.cmd && q_item.last && pixel_count == '0) begin
              mean_red <= '0; mean_green <= '0; mean_blue <= '0;
            end
          end
        end
        cmtm_pkg::ST_NORM, cmtm_pkg::ST_DIV: begin
          if (!div_done) begin
            rem <= rem_next;
            quo <= quo_next;
            dividend <= dividend << 1;
            step <= step + 5'd1;
          end else begin
            step <= '0; rem <= '0; quo <= '0;
            if (state == cmtm_pkg::ST_NORM) begin
              case (ch)
                2'd0:    n_r <= sat;
                2'd1:    n_g <= sat;
                default: n_b <= sat;
              endcase
              if (ch == 2'd2 && !it.cmd && it.last) begin
                // frame end: start the mean divisions on the updated sums
                ch <= 2'd0;
                divisor <= room ? SW'(count_next) : SW'(pixel_count);
                dividend <= room ? add_red : sum_red;
              end else begin
                ch <= ch + 2'd1;
                dividend <= (ch == 2'd0) ? {it.green, {(SW-8){1'b0}}}
                                         : {it.blue, {(SW-8){1'b0}}};
              end
              if (ch == 2'd2 && !it.cmd && room) begin
                sum_red <= add_red;
                sum_green <= add_green;
                sum_blue <= add_blue;
                pixel_count <= count_next;
              end
            end else begin
              ch <= ch + 2'd1;
              case (ch)
                2'd0:    mean_red <= quo_next[7:0];
                2'd1:    mean_green <= quo_next[7:0];
                default: mean_blue <= quo_next[7:0];
              endcase
              dividend <= (ch == 2'd0) ? sum_green : sum_blue;
            end
          end
        end
        cmtm_pkg::ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_res.kind <= it.cmd;
            out_res.mask_bit <= it.cmd && it.below_top &&
                                (val > (select_blue ? blue_limit : red_limit));
            out_res.avg_red <= it.cmd ? 8'd0 : mean_red;
            out_res.avg_green <= it.cmd ? 8'd0 : mean_green;
            out_res.avg_blue <= it.cmd ? 8'd0 : mean_blue;
            out_res.empty_frame <= !it.cmd && (pixel_count == '0);
            if (!it.cmd) begin
              sum_red <= '0; sum_green <= '0; sum_blue <= '0; pixel_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/chroma_mean_threshold_mask.sv =====
// chroma_mean_threshold_mask: top level, register file and front/back join
// depends on cmtm_pkg, cmtm_front, cmtm_back
// pixels come in as transfers with cmd on s_tuser and the frame end on s_tlast; a front
// stage registers each pixel with its channel sum, and the back works one item at a
// time through a shared bit-serial divider: a lit pixel takes three 16-step
// divisions, a classify pixel then goes through the output state, and a black pixel
// skips the divisions; a frame end adds the three 28-step mean divisions and the
// output state, and an empty frame skips the divisions; a result waiting on m_tready
// holds the next result in the back's output state until it is taken
`default_nettype none
module chroma_mean_threshold_mask (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // red, green, blue_value, row
  input  wire logic        s_tuser,  // cmd
  input  wire logic        s_tlast,  // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // mask_bit, avg_red, avg_green, avg_blue, empty_frame
  output logic             m_tuser,  // kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [9:0] black_limit, top_line;
  logic [7:0] red_limit, blue_limit;
  logic       select_blue;
  logic       q_valid, q_ready;
  cmtm_pkg::item_t   q_item;
  cmtm_pkg::result_t res;
  cmtm_pkg::reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx = cmtm_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      black_limit <= 10'd42; red_limit <= 8'd51; blue_limit <= 8'd51;
      top_line <= 10'd15; select_blue <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        cmtm_pkg::REG_BLACK:  black_limit <= pwdata[9:0];
        cmtm_pkg::REG_RED:    red_limit <= pwdata[7:0];
        cmtm_pkg::REG_BLUE:   blue_limit <= pwdata[7:0];
        cmtm_pkg::REG_TOP:    top_line <= pwdata[9:0];
        cmtm_pkg::REG_SELECT: select_blue <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      cmtm_pkg::REG_BLACK:  prdata = 32'(black_limit);
      cmtm_pkg::REG_RED:    prdata = 32'(red_limit);
      cmtm_pkg::REG_BLUE:   prdata = 32'(blue_limit);
      cmtm_pkg::REG_TOP:    prdata = 32'(top_line);
      cmtm_pkg::REG_SELECT: prdata = 32'(select_blue);
      default:              prdata = '0;
    endcase
  end

  // front item layout, lowest bit first: cmd, red, green, blue, row, last
  cmtm_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data({s_tlast, s_tdata[33:0], s_tuser}),
    .black_limit, .top_line, .q_valid, .q_ready, .q_item
  );

  cmtm_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .red_limit, .blue_limit, .select_blue,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {6'd0, res.empty_frame, res.avg_blue, res.avg_green, res.avg_red,
                    res.mask_bit};
  assign m_tuser = res.kind;
  logic unused_hi;
  assign unused_hi = ^s_tdata[39:34];
endmodule
`default_nettype wire

// ===== bench/chroma_mean_threshold_mask_test.sv =====
// chroma_mean_threshold_mask_test: self-checking bench for the chroma mean threshold mask
// depends on cmtm_pkg and chroma_mean_threshold_mask; a directed table, then random
// frames checked against an in-bench model of the normalise / mean / mask behaviour
`timescale 1ns / 100ps
`default_nettype none
module chroma_mean_threshold_mask_test;

  // one pixel: cmd travels on tuser, last on tlast, the rest on tdata
  typedef struct packed {
    logic       last;
    logic [9:0] row;
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
    logic       cmd;
  } pixel_t;

  // output transfer: kind from tuser on top, then tdata lowest bit first: mask_bit,
  // avg_red, avg_green, avg_blue, empty_frame
  typedef struct packed {
    logic       kind;
    logic [5:0] pad;
    logic       empty;
    logic [7:0] avg_b;
    logic [7:0] avg_g;
    logic [7:0] avg_r;
    logic       mask;
  } verdict_t;

  // one row of stimulus; a typed verdict is used in place of the prediction
  typedef struct {
    pixel_t   pix;
    bit       typed;
    verdict_t want;
  } stim_t;

  localparam int unsigned FRAME_MAX = cmtm_pkg::MAX_FRAME_PIXELS;
  localparam int unsigned SETTLE    = 200;
  localparam int unsigned HOLD_OFF  = 3000;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chroma_mean_threshold_mask i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // shadow registers and model state
  logic [9:0]  lim_black;
  logic [7:0]  lim_red, lim_blue;
  logic [9:0]  line_top;
  logic        blue_mode;
  logic [27:0] acc_r, acc_g, acc_b;
  logic [20:0] lit_count;
  logic [7:0]  mean_r, mean_g, mean_b;

  verdict_t verdicts_due[$];
  int       failures = 0;
  bit       hold_req = 1'b0;
  longint unsigned cycles = 0;

  // normalised channel, c*256/total, saturated at 255
  function automatic logic [7:0] chroma(input logic [7:0] c, input logic [9:0] total);
    logic [17:0] q;
    if (total == 10'd0) return 8'd0;
    q = 18'({c, 8'd0}) / 18'(total);
    return (q > 18'd255) ? 8'd255 : q[7:0];
  endfunction

  // model of one accepted pixel; gives a verdict when the pixel causes one
  task automatic model_pixel(input pixel_t p, output bit has, output verdict_t v);
    logic [9:0] total;
    logic       lit;
    logic [7:0] nr, ng, nb, diff, lim;
    total = 10'(p.red) + 10'(p.grn) + 10'(p.blu);
    lit = total > lim_black;
    nr = lit ? chroma(p.red, total) : 8'd0;
    ng = lit ? chroma(p.grn, total) : 8'd0;
    nb = lit ? chroma(p.blu, total) : 8'd0;
    v = '0;
    has = 1'b0;
    if (p.cmd == 1'b0) begin
      // pixels beyond the frame capacity are dropped
      if (lit && lit_count < FRAME_MAX) begin
        acc_r = acc_r + 28'(nr);
        acc_g = acc_g + 28'(ng);
        acc_b = acc_b + 28'(nb);
        lit_count = lit_count + 21'd1;
      end
      if (p.last) begin
        has = 1'b1;
        if (lit_count == '0) begin
          mean_r = 8'd0; mean_g = 8'd0; mean_b = 8'd0;
          v.empty = 1'b1;
        end else begin
          mean_r = 8'(acc_r / 28'(lit_count));
          mean_g = 8'(acc_g / 28'(lit_count));
          mean_b = 8'(acc_b / 28'(lit_count));
        end
        v.avg_r = mean_r;
        v.avg_g = mean_g;
        v.avg_b = mean_b;
        acc_r = '0; acc_g = '0; acc_b = '0; lit_count = '0;
      end
    end else begin
      // classify pass: last flag plays no part
      has = 1'b1;
      if (blue_mode) begin
        diff = (nb > mean_b) ? nb - mean_b : 8'd0;
        lim = lim_blue;
      end else begin
        diff = (nr > mean_r) ? nr - mean_r : 8'd0;
        lim = lim_red;
      end
      v.kind = 1'b1;
      v.mask = (p.row > line_top) && (diff > lim);
    end
  endtask

  // register write: setup then access phase
  task automatic reg_write(input cmtm_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cmtm_pkg::REG_BLACK:  lim_black = val[9:0];
      cmtm_pkg::REG_RED:    lim_red = val[7:0];
      cmtm_pkg::REG_BLUE:   lim_blue = val[7:0];
      cmtm_pkg::REG_TOP:    line_top = val[9:0];
      cmtm_pkg::REG_SELECT: blue_mode = val[0];
      default: ;
    endcase
  endtask

  // offer one pixel, wait for its transfer, then idle for a drawn gap
  task automatic send_pixel(input stim_t s, input bit calm);
    bit       has;
    verdict_t v;
    int       gap;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, s.pix.row, s.pix.blu, s.pix.grn, s.pix.red};
    s_tuser <= s.pix.cmd;
    s_tlast <= s.pix.last;
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    model_pixel(s.pix, has, v);
    if (has) verdicts_due.push_back(s.typed ? s.want : v);
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic pixel_t random_colour(input pixel_t p);
    case ($urandom_range(0, 5))
      0: begin p.red = 8'hFF; p.grn = 8'hFF; p.blu = 8'hFF; end
      1: begin p.red = 8'($urandom_range(0, 20)); p.grn = 8'($urandom_range(0, 20));
               p.blu = 8'($urandom_range(0, 20)); end
      2: begin p.red = 8'($urandom_range(150, 255)); p.grn = 8'($urandom_range(0, 60));
               p.blu = 8'($urandom_range(0, 60)); end
      3: begin p.red = 8'($urandom_range(0, 60)); p.grn = 8'($urandom_range(0, 60));
               p.blu = 8'($urandom_range(150, 255)); end
      default: begin p.red = 8'($urandom); p.grn = 8'($urandom); p.blu = 8'($urandom); end
    endcase
    return p;
  endfunction

  function automatic logic [9:0] random_row();
    case ($urandom_range(0, 4))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return line_top + 10'($urandom_range(0, 2)) - 10'd1;
      default: return 10'($urandom);
    endcase
  endfunction

  // receiver: random readiness, one long hold-off on request
  initial begin : sink
    int       gap;
    int       n;
    bit       calm;
    verdict_t got, want;
    n = 0;
    calm = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_OFF;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 10);
      end
      if (++n % 60 == 0) calm = ~calm;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      forever begin
        @(negedge clk);
        if (m_tvalid) break;
        @(posedge clk);
      end
      got = {m_tuser, m_tdata};
      @(posedge clk);
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        failures++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.kind !== want.kind)
          $display("%0t kind: expected %0d, actual %0d", $time, want.kind, got.kind);
        if (got.mask !== want.mask)
          $display("%0t mask_bit: expected %0d, actual %0d", $time, want.mask, got.mask);
        if (got.avg_r !== want.avg_r)
          $display("%0t avg_red: expected %0d, actual %0d", $time, want.avg_r, got.avg_r);
        if (got.avg_g !== want.avg_g)
          $display("%0t avg_green: expected %0d, actual %0d", $time, want.avg_g, got.avg_g);
        if (got.avg_b !== want.avg_b)
          $display("%0t avg_blue: expected %0d, actual %0d", $time, want.avg_b, got.avg_b);
        if (got.empty !== want.empty)
          $display("%0t empty_frame: expected %0d, actual %0d", $time, want.empty, got.empty);
        if (got.pad !== want.pad)
          $display("%0t padding: expected %h, actual %h", $time, want.pad, got.pad);
        if (got !== want) failures++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("chroma_mean_threshold_mask verification failed");
      $finish;
    end
  end

  function automatic stim_t row_of(input bit c, input int r, input int g, input int b,
                                   input int rw, input bit l, input bit t,
                                   input logic [32:0] w);
    stim_t s;
    s.pix = '0;
    s.pix.cmd = c; s.pix.red = 8'(r); s.pix.grn = 8'(g); s.pix.blu = 8'(b);
    s.pix.row = 10'(rw); s.pix.last = l;
    s.typed = t;
    s.want = w;
    return s;
  endfunction

  initial begin : stimulus
    stim_t   table_rows[$];
    stim_t   s;
    pixel_t  frame[$];
    bit      calm;
    int      len;
    int      phase;
    int      k;
    lim_black = 10'd42; lim_red = 8'd51; lim_blue = 8'd51;
    line_top = 10'd15; blue_mode = 1'b0;
    acc_r = '0; acc_g = '0; acc_b = '0; lit_count = '0;
    mean_r = 8'd0; mean_g = 8'd0; mean_b = 8'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset register values
    table_rows.push_back(row_of(1, 255, 0, 0, 1023, 0, 1, 33'h1_0000_0001)); // reset means
    table_rows.push_back(row_of(1, 0, 0, 255, 1023, 0, 1, 33'h1_0000_0000)); // red mode
    table_rows.push_back(row_of(1, 255, 0, 0, 15, 0, 1, 33'h1_0000_0000));   // on top line
    table_rows.push_back(row_of(1, 0, 0, 0, 0, 0, 1, 33'h1_0000_0000));      // black
    table_rows.push_back(row_of(0, 10, 10, 10, 0, 1, 1, 33'h0_0200_0000));   // empty frame
    table_rows.push_back(row_of(0, 0, 0, 0, 0, 1, 1, 33'h0_0200_0000));
    table_rows.push_back(row_of(0, 14, 14, 14, 0, 1, 1, 33'h0_0200_0000));   // on black limit
    table_rows.push_back(row_of(0, 43, 0, 0, 0, 1, 1, 33'h0_0000_01FE));     // 256 saturates
    table_rows.push_back(row_of(0, 255, 255, 255, 5, 0, 0, 0));              // no result
    table_rows.push_back(row_of(0, 255, 0, 0, 0, 1, 0, 0));
    table_rows.push_back(row_of(1, 255, 0, 0, 16, 1, 0, 0));                 // last ignored
    table_rows.push_back(row_of(1, 43, 0, 0, 20, 0, 0, 0));
    table_rows.push_back(row_of(0, 14, 14, 15, 0, 1, 0, 0));                 // above limit
    table_rows.push_back(row_of(1, 0, 255, 0, 1023, 0, 0, 0));
    table_rows.push_back(row_of(1, 255, 255, 255, 0, 1, 0, 0));
    table_rows.push_back(row_of(0, 0, 0, 255, 1023, 0, 0, 0));
    table_rows.push_back(row_of(0, 255, 255, 0, 512, 1, 0, 0));
    table_rows.push_back(row_of(1, 255, 0, 0, 1023, 0, 0, 0));
    foreach (table_rows[i]) send_pixel(table_rows[i], 1'b0);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      // registers: extremes on the first phases, random afterwards
      case (phase)
        0: begin
          reg_write(cmtm_pkg::REG_BLACK, 0); reg_write(cmtm_pkg::REG_RED, 0);
          reg_write(cmtm_pkg::REG_BLUE, 255); reg_write(cmtm_pkg::REG_TOP, 0);
          reg_write(cmtm_pkg::REG_SELECT, 1);
        end
        1: begin
          reg_write(cmtm_pkg::REG_BLACK, 765); reg_write(cmtm_pkg::REG_RED, 255);
          reg_write(cmtm_pkg::REG_BLUE, 0); reg_write(cmtm_pkg::REG_TOP, 1023);
          reg_write(cmtm_pkg::REG_SELECT, 0);
        end
        2: begin
          reg_write(cmtm_pkg::REG_BLACK, 1023); reg_write(cmtm_pkg::REG_TOP, 1022);
        end
        default: begin
          reg_write(cmtm_pkg::REG_BLACK, $urandom_range(0, 200));
          reg_write(cmtm_pkg::REG_RED, $urandom_range(0, 255));
          reg_write(cmtm_pkg::REG_BLUE, $urandom_range(0, 255));
          reg_write(cmtm_pkg::REG_TOP, $urandom_range(0, 1023));
          reg_write(cmtm_pkg::REG_SELECT, $urandom_range(0, 1));
        end
      endcase
      // the sink stalls for a long stretch while pixels keep coming
      if (phase == 4) hold_req = 1'b1;
      calm = (phase % 3 == 2);
      k = 0;
      while (k < 200) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any field value, including last in the classify pass
          s.pix = 36'({$urandom, $urandom});
          s.typed = 1'b0;
          send_pixel(s, calm);
          k++;
        end else begin
          // well-formed frame: accumulate run, then classify the same pixels
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          frame.delete();
          repeat (len) begin
            s.pix = '0;
            s.pix = random_colour(s.pix);
            s.pix.row = random_row();
            frame.push_back(s.pix);
          end
          s.typed = 1'b0;
          foreach (frame[i]) begin
            s.pix = frame[i];
            s.pix.last = (i == len - 1);
            send_pixel(s, calm);
          end
          foreach (frame[i]) begin
            s.pix = frame[i];
            s.pix.cmd = 1'b1;
            s.pix.last = 1'($urandom_range(0, 1));
            send_pixel(s, calm);
          end
          k += 2 * len;
        end
      end
      drain();
    end

    if (failures == 0) begin
      $display("chroma_mean_threshold_mask verification clean");
    end else begin
      $display("chroma_mean_threshold_mask verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
